// ===== src/mrt_pkg.sv =====
// Package for the min-cost route table: sizes, status codes, state encoding,
// request and entry record types and the stack masking function. No dependencies.
package mrt_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int MAX_STACK_DEPTH = 8;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_NOT_FOUND  = 3'd0,
    ST_FOUND      = 3'd1,
    ST_INSERTED   = 3'd2,
    ST_IMPROVED   = 3'd3,
    ST_NOT_BETTER = 3'd4,
    ST_FULL       = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_COMPARE,
    S_DECIDE,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic        cmd;
    logic [11:0] dest;
    logic [63:0] stack_bits;
    logic [3:0]  stack_len;
    logic [15:0] cost;
    logic [11:0] nhop;
    logic [7:0]  adapter_id;
    logic [7:0]  proto_in;
    logic [15:0] tag;
  } req_t;

  typedef struct packed {
    logic [11:0] dest;
    logic [63:0] stack_bits;
    logic [3:0]  stack_len;
    logic [15:0] cost;
    logic [11:0] nhop;
    logic [7:0]  adapter_id;
    logic [7:0]  proto_in;
    logic [15:0] tag;
  } entry_t;

  function automatic logic [63:0] stack_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < MAX_STACK_DEPTH; b++) begin
      if (4'(b) < len) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ===== src/mrt_if.sv =====
// Channel interfaces of the route table: request and response, each with
// valid, ready and payload. Depends on nothing.
interface mrt_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [11:0] dest;
  logic [63:0] stack_bits;
  logic [3:0]  stack_len;
  logic [15:0] cost;
  logic [11:0] nhop;
  logic [7:0]  adapter_id;
  logic [7:0]  proto_in;
  logic [15:0] tag;
  modport source (output valid, cmd, dest, stack_bits, stack_len, cost, nhop,
                  adapter_id, proto_in, tag, input ready);
  modport sink (input valid, cmd, dest, stack_bits, stack_len, cost, nhop,
                adapter_id, proto_in, tag, output ready);
endinterface

interface mrt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] route_cost;
  logic [11:0] route_nhop;
  logic [7:0]  route_adapter;
  logic [7:0]  route_proto_in;
  logic [15:0] route_tag;
  modport source (output valid, status, route_cost, route_nhop, route_adapter,
                  route_proto_in, route_tag, input ready);
  modport sink (input valid, status, route_cost, route_nhop, route_adapter,
                route_proto_in, route_tag, output ready);
endinterface

// ===== src/min_cost_route_table.sv =====
// Top level of the min-cost route table.
// Depends on mrt_pkg and the channel interfaces in mrt_if.sv.
//
// A request on req either adds a route or looks one up, keyed by destination
// and protocol stack; exactly one response follows on rsp for each request.
// Routes are never removed, so entries fill the table memory in order and a
// fill count marks which are valid. A request scans the valid entries one at
// a time through the memory's single read port, in a read state and a
// compare state per entry, then decides and writes back in a decide state
// and loads the response in a result state. The scan stops at the first
// match; with an empty table a request goes straight to the decide state.
// Requests are taken one at a time; req.ready is high while the block waits
// for a request, also while an earlier response still waits on rsp.
// When rsp is stalled the response register holds, and the block does not
// finish the next request until that response has been taken.
// Reset clears the fill count, so the table starts empty.
module min_cost_route_table
  import mrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  mrt_req_if.sink   req,
  mrt_rsp_if.source rsp
);

  entry_t mem [TABLE_ENTRIES];
  entry_t rdata;
  entry_t wdata;
  logic [IDX_W-1:0] waddr;
  logic we;

  state_t state, state_next;
  req_t   cur;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] idx;
  logic   hit;
  entry_t hit_ent;
  logic   match, last;

  status_t     res_status;
  logic [15:0] res_cost;
  logic [11:0] res_nhop;
  logic [7:0]  res_adapter;
  logic [7:0]  res_proto_in;
  logic [15:0] res_tag;

  logic load;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[idx];
  end

  assign match = (rdata.dest == cur.dest) && (rdata.stack_len == cur.stack_len) &&
                 (rdata.stack_bits == cur.stack_bits);
  assign last = ({1'b0, idx} == count - CNT_W'(1));
  assign load = (state == S_RESULT) && (!rsp.valid || rsp.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (req.valid) state_next = (count == '0) ? S_DECIDE : S_READ;
      S_READ:    state_next = S_COMPARE;
      S_COMPARE: state_next = (match || last) ? S_DECIDE : S_READ;
      S_DECIDE:  state_next = S_RESULT;
      S_RESULT:  if (load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == S_IDLE);
    we = 1'b0;
    waddr = hit ? idx : count[IDX_W-1:0];
    wdata.dest = cur.dest;
    wdata.stack_bits = cur.stack_bits;
    wdata.stack_len = cur.stack_len;
    wdata.cost = cur.cost;
    wdata.nhop = cur.nhop;
    wdata.adapter_id = cur.adapter_id;
    wdata.proto_in = cur.proto_in;
    wdata.tag = cur.tag;
    if (state == S_DECIDE && cur.cmd == CMD_ADD) begin
      if (hit) begin
        we = (cur.cost < hit_ent.cost);
      end else begin
        we = !count[IDX_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (we && !hit) begin
        count <= count + CNT_W'(1);
      end
      if (load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          cur.cmd <= req.cmd;
          cur.dest <= req.dest;
          cur.stack_len <= (req.stack_len > 4'(MAX_STACK_DEPTH)) ?
                           4'(MAX_STACK_DEPTH) : req.stack_len;
          cur.stack_bits <= req.stack_bits & stack_mask(req.stack_len);
          cur.cost <= req.cost;
          cur.nhop <= req.nhop;
          cur.adapter_id <= req.adapter_id;
          cur.proto_in <= req.proto_in;
          cur.tag <= req.tag;
          idx <= '0;
          hit <= 1'b0;
        end
      end
      S_COMPARE: begin
        if (match) begin
          hit <= 1'b1;
          hit_ent <= rdata;
        end else if (!last) begin
          idx <= idx + IDX_W'(1);
        end
      end
      S_DECIDE: begin
        res_cost <= '0;
        res_nhop <= '0;
        res_adapter <= '0;
        res_proto_in <= '0;
        res_tag <= '0;
        if (cur.cmd == CMD_LOOKUP) begin
          if (hit) begin
            res_status <= ST_FOUND;
            res_cost <= hit_ent.cost;
            res_nhop <= hit_ent.nhop;
            res_adapter <= hit_ent.adapter_id;
            res_proto_in <= hit_ent.proto_in;
            res_tag <= hit_ent.tag;
          end else begin
            res_status <= ST_NOT_FOUND;
          end
        end else if (hit) begin
          res_status <= (cur.cost < hit_ent.cost) ? ST_IMPROVED : ST_NOT_BETTER;
        end else begin
          res_status <= count[IDX_W] ? ST_FULL : ST_INSERTED;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.status <= res_status;
      rsp.route_cost <= res_cost;
      rsp.route_nhop <= res_nhop;
      rsp.route_adapter <= res_adapter;
      rsp.route_proto_in <= res_proto_in;
      rsp.route_tag <= res_tag;
    end
  end

endmodule

// ===== src/mrt_checker.sv =====
// Port-level checks for the min-cost route table, bound to the top level.
// Depends on mrt_pkg.
module mrt_checker
  import mrt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  rsp_status,
  input logic [15:0] rsp_route_cost,
  input logic [15:0] rsp_route_tag
);

  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
    end
  end

  a_rsp_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
    else $error("response dropped or changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("response without a request");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_status <= 3'(ST_FULL))
    else $error("status code out of range");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != 3'(ST_FOUND) |-> rsp_route_cost == '0 && rsp_route_tag == '0)
    else $error("route fields not zero without a lookup hit");

endmodule

bind min_cost_route_table mrt_checker u_mrt_checker (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_status(rsp.status), .rsp_route_cost(rsp.route_cost),
  .rsp_route_tag(rsp.route_tag)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for min_cost_route_table: a directed table, then random
// add and lookup requests against a predictor of the route store, with random idling.
// Depends on mrt_pkg, the channel interfaces in mrt_if.sv and the block's RTL.
module tb_top;
  import mrt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] cost;
    logic [11:0] nhop;
    logic [7:0]  adapter;
    logic [7:0]  proto_in;
    logic [15:0] tag;
  } route_rsp_t;

  typedef struct packed {
    req_t       r;
    logic       typed;
    route_rsp_t rsp;
  } dir_row_t;

  localparam int RANDOM_ITEMS = 1725;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int TAIL_CYCLES = 600;
  localparam int NUM_DIR = 14;

  logic clk;
  logic rst;
  mrt_req_if req ();
  mrt_rsp_if rsp ();

  min_cost_route_table dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  logic        tbl_valid [TABLE_ENTRIES];
  entry_t      tbl_entry [TABLE_ENTRIES];
  route_rsp_t  route_expect_q [$];
  logic [11:0] pool_dest [$];
  logic [63:0] pool_stack [$];
  logic [3:0]  pool_len [$];
  int          errors = 0;
  int          cycles = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_full = 0;
  int          n_improved = 0;
  int          n_found = 0;
  bit          quiet = 0;
  dir_row_t    dir_tbl [NUM_DIR];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic route_rsp_t predict_route(req_t r);
    route_rsp_t o;
    logic [3:0]  len;
    logic [63:0] stk;
    int hit, free_slot;
    o = '0;
    hit = -1;
    free_slot = -1;
    len = (r.stack_len > MAX_STACK_DEPTH) ? 4'(MAX_STACK_DEPTH) : r.stack_len;
    stk = '0;
    for (int b = 0; b < 8; b++) begin
      if (b < len) stk[b*8 +: 8] = r.stack_bits[b*8 +: 8];
    end
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (tbl_valid[k]) begin
        if (hit < 0 && tbl_entry[k].dest == r.dest && tbl_entry[k].stack_len == len &&
            tbl_entry[k].stack_bits == stk) hit = k;
      end else if (free_slot < 0) begin
        free_slot = k;
      end
    end
    if (r.cmd == CMD_LOOKUP) begin
      if (hit >= 0) begin
        o.status = ST_FOUND;
        o.cost = tbl_entry[hit].cost;
        o.nhop = tbl_entry[hit].nhop;
        o.adapter = tbl_entry[hit].adapter_id;
        o.proto_in = tbl_entry[hit].proto_in;
        o.tag = tbl_entry[hit].tag;
      end else begin
        o.status = ST_NOT_FOUND;
      end
    end else if (hit >= 0) begin
      if (r.cost < tbl_entry[hit].cost) begin
        o.status = ST_IMPROVED;
        tbl_entry[hit].cost = r.cost;
        tbl_entry[hit].nhop = r.nhop;
        tbl_entry[hit].adapter_id = r.adapter_id;
        tbl_entry[hit].proto_in = r.proto_in;
        tbl_entry[hit].tag = r.tag;
      end else begin
        o.status = ST_NOT_BETTER;
      end
    end else if (free_slot >= 0) begin
      o.status = ST_INSERTED;
      tbl_valid[free_slot] = 1'b1;
      tbl_entry[free_slot] = '{r.dest, stk, len, r.cost, r.nhop, r.adapter_id,
                               r.proto_in, r.tag};
      pool_dest.push_back(r.dest);
      pool_stack.push_back(stk);
      pool_len.push_back(len);
    end else begin
      o.status = ST_FULL;
    end
    return o;
  endfunction

  function automatic int draw_wait();
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic req_t random_route_req();
    req_t r;
    int p;
    r.cmd = $urandom_range(0, 2) == 0 ? CMD_LOOKUP : CMD_ADD;
    r.dest = 12'($urandom_range(0, 4095));
    r.stack_bits = {$urandom(), $urandom()};
    r.stack_len = 4'($urandom_range(0, 15));
    r.cost = 16'($urandom_range(0, 65535));
    r.nhop = 12'($urandom_range(0, 4095));
    r.adapter_id = 8'($urandom_range(0, 255));
    r.proto_in = 8'($urandom_range(0, 255));
    r.tag = 16'($urandom_range(0, 65535));
    if (pool_dest.size() > 0 && $urandom_range(0, 9) < 6) begin
      p = $urandom_range(0, pool_dest.size() - 1);
      r.dest = pool_dest[p];
      for (int b = 0; b < 8; b++) begin
        if (b < pool_len[p]) r.stack_bits[b*8 +: 8] = pool_stack[p][b*8 +: 8];
      end
      r.stack_len = (pool_len[p] == 4'd8) ? 4'($urandom_range(8, 15)) : pool_len[p];
      if ($urandom_range(0, 1) == 0) r.cost = 16'($urandom_range(0, 255));
    end
    return r;
  endfunction

  task automatic send_route_req(req_t r, logic typed, route_rsp_t typed_rsp);
    int gap;
    route_rsp_t e;
    gap = draw_wait();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= r.cmd;
    req.dest <= r.dest;
    req.stack_bits <= r.stack_bits;
    req.stack_len <= r.stack_len;
    req.cost <= r.cost;
    req.nhop <= r.nhop;
    req.adapter_id <= r.adapter_id;
    req.proto_in <= r.proto_in;
    req.tag <= r.tag;
    do @(posedge clk); while (!req.ready);
    e = predict_route(r);
    if (e.status == ST_FULL) n_full++;
    if (e.status == ST_IMPROVED) n_improved++;
    if (e.status == ST_FOUND) n_found++;
    route_expect_q.push_back(typed ? typed_rsp : e);
    n_sent++;
  endtask

  initial begin : rsp_check
    int stall;
    route_rsp_t e, a;
    @(negedge rst);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      a = '{rsp.status, rsp.route_cost, rsp.route_nhop, rsp.route_adapter,
            rsp.route_proto_in, rsp.route_tag};
      if (route_expect_q.size() == 0) begin
        $display("%0t unexpected response %h", $time, a);
        errors++;
      end else begin
        e = route_expect_q.pop_front();
        n_checked++;
        if (a.status !== e.status)
          $display("%0t status exp %0d got %0d", $time, e.status, a.status);
        if (a.cost !== e.cost)
          $display("%0t route_cost exp %h got %h", $time, e.cost, a.cost);
        if (a.nhop !== e.nhop)
          $display("%0t route_nhop exp %h got %h", $time, e.nhop, a.nhop);
        if (a.adapter !== e.adapter)
          $display("%0t route_adapter exp %h got %h", $time, e.adapter, a.adapter);
        if (a.proto_in !== e.proto_in)
          $display("%0t route_proto_in exp %h got %h", $time, e.proto_in, a.proto_in);
        if (a.tag !== e.tag)
          $display("%0t route_tag exp %h got %h", $time, e.tag, a.tag);
        if (a !== e) errors++;
      end
    end
  end

  initial begin : stim
    for (int k = 0; k < TABLE_ENTRIES; k++) tbl_valid[k] = 1'b0;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.cmd <= CMD_ADD;
    req.dest <= '0;
    req.stack_bits <= '0;
    req.stack_len <= '0;
    req.cost <= '0;
    req.nhop <= '0;
    req.adapter_id <= '0;
    req.proto_in <= '0;
    req.tag <= '0;
    rsp.ready <= 1'b0;
    // Rows marked typed carry their expected response; the rest use the predictor.
    dir_tbl = '{
      '{'{CMD_LOOKUP, 12'h000, 64'h0, 4'd0, 16'h0, 12'h0, 8'h0, 8'h0, 16'h0},
        1'b1, '{ST_NOT_FOUND, 16'h0, 12'h0, 8'h0, 8'h0, 16'h0}},
      '{'{CMD_ADD, 12'h000, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 16'hFFFF, 12'hFFF, 8'hFF,
          8'hFF, 16'hFFFF}, 1'b1, '{ST_INSERTED, 16'h0, 12'h0, 8'h0, 8'h0, 16'h0}},
      '{'{CMD_LOOKUP, 12'h000, 64'h0, 4'd0, 16'h0, 12'h0, 8'h0, 8'h0, 16'h0},
        1'b1, '{ST_FOUND, 16'hFFFF, 12'hFFF, 8'hFF, 8'hFF, 16'hFFFF}},
      '{'{CMD_ADD, 12'h000, 64'h0, 4'd0, 16'hFFFF, 12'h1, 8'h1, 8'h1, 16'h1},
        1'b1, '{ST_NOT_BETTER, 16'h0, 12'h0, 8'h0, 8'h0, 16'h0}},
      '{'{CMD_ADD, 12'h000, 64'h0, 4'd0, 16'h0, 12'h0, 8'h0, 8'h0, 16'h0},
        1'b1, '{ST_IMPROVED, 16'h0, 12'h0, 8'h0, 8'h0, 16'h0}},
      '{'{CMD_LOOKUP, 12'h000, 64'h0, 4'd0, 16'h0, 12'h0, 8'h0, 8'h0, 16'h0},
        1'b1, '{ST_FOUND, 16'h0, 12'h0, 8'h0, 8'h0, 16'h0}},
      '{'{CMD_ADD, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 16'h1234, 12'habc, 8'h5A,
          8'hA5, 16'h8001}, 1'b1, '{ST_INSERTED, 16'h0, 12'h0, 8'h0, 8'h0, 16'h0}},
      '{'{CMD_LOOKUP, 12'hFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 16'h0, 12'h0, 8'h0,
          8'h0, 16'h0}, 1'b1, '{ST_FOUND, 16'h1234, 12'habc, 8'h5A, 8'hA5, 16'h8001}},
      '{'{CMD_ADD, 12'h123, 64'hDEAD_BEEF_CAFE_0201, 4'd2, 16'h0100, 12'h055, 8'h11,
          8'h22, 16'h3333}, 1'b0, '0},
      '{'{CMD_LOOKUP, 12'h123, 64'h1111_2222_3333_0201, 4'd2, 16'hFFFF, 12'hFFF, 8'hFF,
          8'hFF, 16'hFFFF}, 1'b0, '0},
      '{'{CMD_LOOKUP, 12'h123, 64'h0000_0000_0000_0201, 4'd3, 16'h0, 12'h0, 8'h0, 8'h0,
          16'h0}, 1'b0, '0},
      '{'{CMD_LOOKUP, 12'h000, 64'h0, 4'd1, 16'h0, 12'h0, 8'h0, 8'h0, 16'h0},
        1'b0, '0},
      '{'{CMD_ADD, 12'h123, 64'h0000_0000_0000_0201, 4'd2, 16'h00FF, 12'h0, 8'h0,
          8'h0, 16'h0}, 1'b0, '0},
      '{'{CMD_LOOKUP, 12'h123, 64'hFFFF_FFFF_FFFF_0201, 4'd2, 16'h0, 12'h0, 8'h0, 8'h0,
          16'h0}, 1'b0, '0}
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_tbl[i]) send_route_req(dir_tbl[i].r, dir_tbl[i].typed, dir_tbl[i].rsp);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 300 == 150) quiet = ~quiet;
      if (i == RANDOM_ITEMS / 2) begin
        req.valid <= 1'b0;
        while (route_expect_q.size() != 0) @(posedge clk);
      end
      send_route_req(random_route_req(), 1'b0, '0);
    end
    req.valid <= 1'b0;
    while (route_expect_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d requests, checked %0d responses: %0d hits, %0d improvements,",
             n_sent, n_checked, n_found, n_improved);
    $display("%0d table-full adds, %0d routes stored.", n_full, pool_dest.size());
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
